@@ rtl/zzsd_pkg.sv @@
// Shared constants and types for the zigzag swing detector.
`timescale 1ns / 1ps
package zzsd_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int PRICE_BITS_DEF = 32;

  // deviation register: unsigned Q16 fraction of price
  localparam int DEV_BITS = 20;
  localparam int FRAC_BITS = 16;
  localparam logic [DEV_BITS-1:0] DEV_RESET = 20'd3277;

  // result queue between the update stage and the output channel
  localparam int RES_FIFO_DEPTH = 4;

  // write strobes into the result queue; push_b only together with push_a
  typedef struct packed {
    logic push_a;
    logic push_b;
  } zzsd_fifo_wr_t;

endpackage

@@ rtl/zzsd_in_if.sv @@
// Candle input channel: valid/ready handshake with the candle payload.
`timescale 1ns / 1ps
interface zzsd_in_if #(
  parameter int PRICE_BITS = zzsd_pkg::PRICE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;
  logic                  end_of_series;

  modport source (
    output valid, high_price, low_price, close_price, end_of_series,
    input  ready
  );
  modport sink (
    input  valid, high_price, low_price, close_price, end_of_series,
    output ready
  );
endinterface

@@ rtl/zzsd_out_if.sv @@
// Swing point output channel: valid/ready handshake with the swing payload.
`timescale 1ns / 1ps
interface zzsd_out_if #(
  parameter int INDEX_BITS = zzsd_pkg::INDEX_BITS_DEF,
  parameter int PRICE_BITS = zzsd_pkg::PRICE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] swing_index;
  logic [PRICE_BITS-1:0] swing_price;
  logic                  provisional;
  logic                  last_of_run;

  modport source (
    output valid, swing_index, swing_price, provisional, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, swing_index, swing_price, provisional, last_of_run,
    output ready
  );
endinterface

@@ rtl/zzsd_res_fifo.sv @@
// Small result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps
module zzsd_res_fifo #(
  parameter int WIDTH = 58,
  parameter int DEPTH = zzsd_pkg::RES_FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  zzsd_pkg::zzsd_fifo_wr_t wr,
  input  logic [WIDTH-1:0]       wr_data_a,
  input  logic [WIDTH-1:0]       wr_data_b,
  output logic                   room_two,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output logic [WIDTH-1:0]       rd_data
);
  import zzsd_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic [CNT_BITS-1:0] n_wr;
  logic                pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  assign room_two = (count_r <= CNT_BITS'(DEPTH - 2));
  assign n_wr     = CNT_BITS'(wr.push_a) + CNT_BITS'(wr.push_b);
  assign count_nxt = count_r + n_wr - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_BITS'(n_wr);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push_a) begin
      mem_r[wr_ptr_r] <= wr_data_a;
    end
    if (wr.push_b) begin
      mem_r[wr_ptr_r + PTR_BITS'(1)] <= wr_data_b;
    end
  end

  a_wr_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.push_a || wr.push_b) |-> (count_r + n_wr <= CNT_BITS'(DEPTH)))
    else $error("result queue overrun");

  a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push_b |-> wr.push_a)
    else $error("second write without first");

endmodule

@@ rtl/zigzag_swing_detector_core.sv @@
// Top level of the zigzag swing detector: candle stage, trend update, result queue.
`timescale 1ns / 1ps
// Zigzag swing detector, percent-deviation form.
// in_ch carries one candle per beat (high, low, close, end_of_series); out_ch
// carries swing points (index, price, provisional, last_of_run). cfg_wr_en with
// cfg_wr_data loads the Q16 deviation threshold; zero mutes all output.
// A candle is registered in the candle stage; when that stage advances, the trend
// update and the queue write of its swing points happen at the same edge.
// Throughput: one candle per cycle while the queue has room for two swing points.
// A candle that yields two swing points (confirmed plus provisional) needs two
// output beats; the four-entry result queue with one read port sets that. The
// deviation products dev*price are formed in the candle stage, so the trend loop
// holds only subtracts and compares. Reset (rst_n low, synchronous): threshold
// back to 3277, series cleared, queue emptied. When out_ch stalls, the queue
// fills, the candle stage holds and in_ch.ready drops; nothing is lost or repeated.
module zigzag_swing_detector_core #(
  parameter int INDEX_BITS = zzsd_pkg::INDEX_BITS_DEF,
  parameter int PRICE_BITS = zzsd_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  zzsd_in_if.sink                       in_ch,
  zzsd_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [zzsd_pkg::DEV_BITS-1:0] cfg_wr_data
);
  import zzsd_pkg::*;

  localparam int PROD_BITS = DEV_BITS + PRICE_BITS;
  localparam int RES_BITS  = INDEX_BITS + PRICE_BITS + 2;

  typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DOWN} dir_t;

  // threshold register
  logic [DEV_BITS-1:0] dev_r;

  // candle stage: prices plus their products with the threshold
  logic                  s2_valid_r;
  logic [PRICE_BITS-1:0] s2_hi_r, s2_lo_r, s2_cl_r;
  logic                  s2_last_r;
  logic [PROD_BITS-1:0]  s2_hi_prod_r, s2_lo_prod_r, s2_cl_prod_r;
  logic                  s2_go;
  logic                  in_beat;

  // series state
  dir_t                  dir_r, dir_nxt;
  logic                  started_r, started_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] pend_idx_r, pend_idx_nxt;
  logic [PRICE_BITS-1:0] pend_price_r, pend_price_nxt;
  logic [PROD_BITS-1:0]  pend_prod_r, pend_prod_nxt;
  logic [PROD_BITS-1:0]  refresh_prod;

  // deviation tests against the pending swing
  logic                  hi_above, lo_below;
  logic [PRICE_BITS-1:0] up_d, dn_d;
  logic                  far_up, far_dn;

  // results of this candle
  logic                  emit_conf, emit_prov;
  logic [INDEX_BITS-1:0] prov_idx;
  logic [PRICE_BITS-1:0] prov_price;
  logic [RES_BITS-1:0]   res_conf, res_prov;
  zzsd_fifo_wr_t         fifo_wr;
  logic [RES_BITS-1:0]   wr_data_a;
  logic                  room_two;
  logic [RES_BITS-1:0]   rd_data;

  // advance the candle stage only when the queue can take two swing points
  assign s2_go       = s2_valid_r && room_two;
  assign in_ch.ready = !s2_valid_r || s2_go;
  assign in_beat     = in_ch.valid && in_ch.ready;

  // keep dev*pending price current across threshold writes
  assign refresh_prod = PROD_BITS'(dev_r) * PROD_BITS'(pend_price_r);

  assign hi_above = (s2_hi_r > pend_price_r);
  assign lo_below = (pend_price_r > s2_lo_r);
  assign up_d     = hi_above ? (s2_hi_r - pend_price_r) : '0;
  assign dn_d     = lo_below ? (pend_price_r - s2_lo_r) : '0;
  // delta*65536 >= dev*price, delta nonzero
  assign far_up = hi_above &&
                  (PROD_BITS'({up_d, {FRAC_BITS{1'b0}}}) >= pend_prod_r);
  assign far_dn = lo_below &&
                  (PROD_BITS'({dn_d, {FRAC_BITS{1'b0}}}) >= pend_prod_r);

  always_comb begin
    dir_nxt        = dir_r;
    started_nxt    = started_r;
    cnt_nxt        = cnt_r;
    pend_idx_nxt   = pend_idx_r;
    pend_price_nxt = pend_price_r;
    pend_prod_nxt  = pend_prod_r;
    emit_conf      = 1'b0;
    emit_prov      = 1'b0;

    if (!started_r) begin
      // first candle seeds the swing with its close
      started_nxt    = 1'b1;
      pend_idx_nxt   = '0;
      pend_price_nxt = s2_cl_r;
      pend_prod_nxt  = s2_cl_prod_r;
      cnt_nxt        = INDEX_BITS'(1);
    end else begin
      unique case (dir_r)
        DIR_UP: begin
          if (hi_above) begin
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_hi_r;
            pend_prod_nxt  = s2_hi_prod_r;
          end else if (far_dn) begin
            emit_conf      = 1'b1;
            dir_nxt        = DIR_DOWN;
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_lo_r;
            pend_prod_nxt  = s2_lo_prod_r;
          end
        end
        DIR_DOWN: begin
          if (s2_lo_r < pend_price_r) begin
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_lo_r;
            pend_prod_nxt  = s2_lo_prod_r;
          end else if (far_up) begin
            emit_conf      = 1'b1;
            dir_nxt        = DIR_UP;
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_hi_r;
            pend_prod_nxt  = s2_hi_prod_r;
          end
        end
        default: begin
          if (far_up) begin
            emit_conf      = 1'b1;
            dir_nxt        = DIR_UP;
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_hi_r;
            pend_prod_nxt  = s2_hi_prod_r;
          end else if (far_dn) begin
            emit_conf      = 1'b1;
            dir_nxt        = DIR_DOWN;
            pend_idx_nxt   = cnt_r;
            pend_price_nxt = s2_lo_r;
            pend_prod_nxt  = s2_lo_prod_r;
          end
        end
      endcase
      cnt_nxt = cnt_r + INDEX_BITS'(1);
    end

    // flush the pending swing at the end of the series, then restart
    prov_idx   = pend_idx_nxt;
    prov_price = pend_price_nxt;
    if (s2_last_r) begin
      emit_prov      = (dir_nxt != DIR_NONE);
      dir_nxt        = DIR_NONE;
      started_nxt    = 1'b0;
      cnt_nxt        = '0;
      pend_idx_nxt   = '0;
      pend_price_nxt = '0;
      pend_prod_nxt  = '0;
    end

    // a zero threshold mutes everything
    if (dev_r == '0) begin
      emit_conf = 1'b0;
      emit_prov = 1'b0;
    end
  end

  // pack as {index, price, provisional, last_of_run}
  assign res_conf = {pend_idx_r, pend_price_r, 1'b0, !emit_prov};
  assign res_prov = {prov_idx, prov_price, 1'b1, 1'b1};

  always_comb begin
    fifo_wr.push_a = s2_go && (emit_conf || emit_prov);
    fifo_wr.push_b = s2_go && emit_conf && emit_prov;
    wr_data_a      = emit_conf ? res_conf : res_prov;
  end

  // control and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r        <= DEV_RESET;
      s2_valid_r   <= 1'b0;
      dir_r        <= DIR_NONE;
      started_r    <= 1'b0;
      cnt_r        <= '0;
      pend_idx_r   <= '0;
      pend_price_r <= '0;
      pend_prod_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        dev_r <= cfg_wr_data;
      end
      if (in_beat) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        dir_r        <= dir_nxt;
        started_r    <= started_nxt;
        cnt_r        <= cnt_nxt;
        pend_idx_r   <= pend_idx_nxt;
        pend_price_r <= pend_price_nxt;
        pend_prod_r  <= pend_prod_nxt;
      end else begin
        pend_prod_r <= refresh_prod;
      end
    end
  end

  // candle stage payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s2_hi_r      <= in_ch.high_price;
      s2_lo_r      <= in_ch.low_price;
      s2_cl_r      <= in_ch.close_price;
      s2_last_r    <= in_ch.end_of_series;
      s2_hi_prod_r <= PROD_BITS'(dev_r) * PROD_BITS'(in_ch.high_price);
      s2_lo_prod_r <= PROD_BITS'(dev_r) * PROD_BITS'(in_ch.low_price);
      s2_cl_prod_r <= PROD_BITS'(dev_r) * PROD_BITS'(in_ch.close_price);
    end
  end

  zzsd_res_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (fifo_wr),
    .wr_data_a (wr_data_a),
    .wr_data_b (res_prov),
    .room_two  (room_two),
    .rd_valid  (out_ch.valid),
    .rd_ready  (out_ch.ready),
    .rd_data   (rd_data)
  );

  assign out_ch.swing_index = rd_data[RES_BITS-1 -: INDEX_BITS];
  assign out_ch.swing_price = rd_data[PRICE_BITS+1 : 2];
  assign out_ch.provisional = rd_data[1];
  assign out_ch.last_of_run = rd_data[0];

  a_idle_series: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (dir_r == DIR_NONE) && (cnt_r == '0))
    else $error("trend set outside a series");

  a_flush_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_last_r) |=> !started_r && (pend_price_r == '0))
    else $error("series not restarted after end beat");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !room_two) |-> !in_ch.ready)
    else $error("candle accepted while result queue is short of room");

  a_muted: assert property (@(posedge clk) disable iff (!rst_n)
    (dev_r == '0) |-> !fifo_wr.push_a)
    else $error("swing point written with zero threshold");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the zigzag swing detector core.
`timescale 1ns / 1ps
// Candles go in on in_ch, one beat each. For every accepted candle the
// testbench runs its own swing tracker and queues the swing points that the
// candle must produce. Each swing point beat on out_ch is checked field by
// field against the oldest queued point. The run goes like this:
//   - one reset, then a short directed set at the reset threshold: a lone
//     candle, a zero-price series, full-scale prices, trend extension and
//     reversal, an undecided series, and the exact threshold boundary
//   - random phases at several thresholds, zero and full scale among them.
//     Most series are random walks; the rest are noise candles and series
//     cut short by an early end flag.
// Both channels idle at random. Once, the receiver holds off for a long
// stretch so that the result queue fills and in_ch.ready drops.
module testbench;
  import zzsd_pkg::*;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int PRICE_W = PRICE_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int SQUEEZE_CYCLES = 300;  // the one long receiver hold-off
  localparam int SQUEEZE_AFTER = 30;  // swing points seen before it starts

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_t;

  typedef struct packed {
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic               end_of_series;
  } candle_t;

  typedef struct packed {
    logic [IDX_W-1:0]   swing_index;
    logic [PRICE_W-1:0] swing_price;
    logic               provisional;
    logic               last_of_run;
  } swing_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [DEV_BITS-1:0] cfg_wr_data;

  zzsd_in_if #(.PRICE_BITS(PRICE_W)) in_ch ();
  zzsd_out_if #(.INDEX_BITS(IDX_W), .PRICE_BITS(PRICE_W)) out_ch ();

  zigzag_swing_detector_core #(
    .INDEX_BITS(IDX_W),
    .PRICE_BITS(PRICE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Candles waiting for the driver, and swing points waiting for the block.
  candle_t candle_q[$];
  swing_t  swing_q[$];

  int candles_queued = 0;
  int candles_taken = 0;
  int swings_seen = 0;
  int mismatches = 0;

  // Tracker state: a private copy of the threshold and the series.
  logic [DEV_BITS-1:0] dev_model = DEV_RESET;
  trend_t              trend_state = TREND_NONE;
  logic [IDX_W-1:0]    pend_index = '0;
  logic [PRICE_W-1:0]  pend_price = '0;
  logic [IDX_W-1:0]    candle_count = '0;
  bit                  series_open = 1'b0;

  // Idling state for both sides.
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int recv_calm = 0;
  bit squeeze_done = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pick an idle length: mostly none or short, a few long, and now and then
  // start a calm stretch with no idling at all.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A move counts when it is nonzero and move * 2^16 >= threshold * price.
  function automatic bit far_enough(logic [PRICE_W-1:0] delta, logic [PRICE_W-1:0] base);
    logic [63:0] lhs;
    logic [63:0] rhs;
    if (delta == '0) return 1'b0;
    lhs = 64'(delta) << FRAC_BITS;
    rhs = 64'(dev_model) * 64'(base);
    return lhs >= rhs;
  endfunction

  // Advance the tracker by one candle and queue the swing points it yields.
  task automatic track_candle(input candle_t c);
    swing_t             found[2];
    int                 n;
    logic [PRICE_W-1:0] sp;
    logic [PRICE_W-1:0] up_move;
    logic [PRICE_W-1:0] down_move;
    bit                 confirm;
    trend_t             next_trend;
    n = 0;
    sp = pend_price;
    confirm = 1'b0;
    next_trend = trend_state;
    if (!series_open) begin
      // seed the pending swing with the first close
      series_open = 1'b1;
      pend_index = '0;
      pend_price = c.close_price;
      candle_count = IDX_W'(1);
    end else begin
      up_move = (c.high_price > sp) ? c.high_price - sp : '0;
      down_move = (sp > c.low_price) ? sp - c.low_price : '0;
      case (trend_state)
        TREND_UP: begin
          if (c.high_price > sp) begin
            pend_index = candle_count;
            pend_price = c.high_price;
          end else if (far_enough(down_move, sp)) begin
            confirm = 1'b1;
            next_trend = TREND_DOWN;
          end
        end
        TREND_DOWN: begin
          if (c.low_price < sp) begin
            pend_index = candle_count;
            pend_price = c.low_price;
          end else if (far_enough(up_move, sp)) begin
            confirm = 1'b1;
            next_trend = TREND_UP;
          end
        end
        default: begin
          if (far_enough(up_move, sp)) begin
            confirm = 1'b1;
            next_trend = TREND_UP;
          end else if (far_enough(down_move, sp)) begin
            confirm = 1'b1;
            next_trend = TREND_DOWN;
          end
        end
      endcase
      if (confirm) begin
        // the old pending swing is now confirmed; start a new one here
        if (dev_model != '0) begin
          found[n] = '{pend_index, sp, 1'b0, 1'b0};
          n++;
        end
        trend_state = next_trend;
        pend_index = candle_count;
        pend_price = (next_trend == TREND_UP) ? c.high_price : c.low_price;
      end
      candle_count = candle_count + IDX_W'(1);
    end
    if (c.end_of_series) begin
      // flush the pending swing as provisional, then restart the series
      if (trend_state != TREND_NONE && dev_model != '0) begin
        found[n] = '{pend_index, pend_price, 1'b1, 1'b0};
        n++;
      end
      trend_state = TREND_NONE;
      pend_index = '0;
      pend_price = '0;
      candle_count = '0;
      series_open = 1'b0;
    end
    if (n > 0) found[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) swing_q.push_back(found[k]);
  endtask

  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Driver: hold the current beat until it is taken, then either idle or
  // launch the next queued candle. Track each candle at its accepting edge.
  always @(posedge clk) begin : drive_candles
    candle_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_candle('{in_ch.high_price, in_ch.low_price, in_ch.close_price,
                       in_ch.end_of_series});
        candles_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (candle_q.size() > 0) begin
          nxt = candle_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.high_price <= nxt.high_price;
          in_ch.low_price <= nxt.low_price;
          in_ch.close_price <= nxt.close_price;
          in_ch.end_of_series <= nxt.end_of_series;
          send_gap = draw_gap(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each swing point beat, then decide ready for the next
  // cycle. Start the long hold-off once enough swing points have passed.
  always @(posedge clk) begin : watch_swings
    swing_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        swings_seen++;
        if (swing_q.size() == 0) begin
          $display("%0t: swing point mismatch, expected none actual index %0d price %0d",
                   $time, out_ch.swing_index, out_ch.swing_price);
          mismatches++;
        end else begin
          want = swing_q.pop_front();
          check_field("swing_index", 64'(want.swing_index), 64'(out_ch.swing_index));
          check_field("swing_price", 64'(want.swing_price), 64'(out_ch.swing_price));
          check_field("provisional", 64'(want.provisional), 64'(out_ch.provisional));
          check_field("last_of_run", 64'(want.last_of_run), 64'(out_ch.last_of_run));
        end
      end
      if (!squeeze_done && swings_seen >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = draw_gap(recv_calm);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_candle(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                              input logic [PRICE_W-1:0] cl, input logic eos);
    candle_q.push_back('{hi, lo, cl, eos});
    candles_queued++;
  endtask

  // Wait until every candle is taken and every swing point has come back,
  // then give the update stage time to settle before touching the register.
  task automatic wait_idle();
    while (candles_taken != candles_queued || swing_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_deviation(input logic [DEV_BITS-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dev_model = v;
  endtask

  // Random series: mostly random walks with a trend bias, some pure noise,
  // some walks broken off by an early end flag.
  task automatic random_candles(input int target);
    int          made;
    int          len;
    int          kind;
    int          sh;
    logic [63:0] p;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] u;
    logic [63:0] d;
    logic [31:0] span;
    bit          rising;
    bit          eos;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(30, 60);
      if (len > target - made) len = target - made;
      case ($urandom_range(0, 3))
        0: p = 64'($urandom_range(0, 200));
        1: p = 64'($urandom_range(1000, 100000));
        2: p = 64'($urandom());
        default: p = 64'hFFFF_FFFF - 64'($urandom_range(0, 5000));
      endcase
      sh = $urandom_range(1, 7);
      rising = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        if (kind == 0) begin
          queue_candle($urandom(), $urandom(), $urandom(), $urandom_range(0, 3) == 0);
        end else begin
          span = 32'(p >> sh) + $urandom_range(0, 64);
          if (rising) begin
            u = 64'($urandom_range(0, span));
            d = 64'($urandom_range(0, span >> 1));
          end else begin
            u = 64'($urandom_range(0, span >> 1));
            d = 64'($urandom_range(0, span));
          end
          hi = p + u;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          lo = (p > d) ? p - d : 64'd0;
          eos = (k == len - 1) || (kind == 1 && $urandom_range(0, 15) == 0);
          queue_candle(hi[31:0], lo[31:0], p[31:0], eos);
          if ($urandom_range(0, 9) < 7) p = rising ? hi : lo;
          else p = lo + ((hi - lo) >> 1);
          if ($urandom_range(0, 4) == 0) rising = !rising;
        end
        made++;
      end
    end
  endtask

  initial begin : run_test
    logic [DEV_BITS-1:0] phase_dev[6];
    int                  phase_len[6];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = DEV_RESET;
    in_ch.valid = 1'b0;
    in_ch.high_price = '0;
    in_ch.low_price = '0;
    in_ch.close_price = '0;
    in_ch.end_of_series = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed set at the reset threshold.
    // lone candle that also ends its series: nothing comes out
    queue_candle(32'd1010, 32'd990, 32'd1000, 1'b1);
    // zero seed price: a flat candle is no move, any rise is, then a
    // reversal on the end candle gives a confirmed and a provisional point
    queue_candle(32'd0, 32'd0, 32'd0, 1'b0);
    queue_candle(32'd0, 32'd0, 32'd7, 1'b0);
    queue_candle(32'd1, 32'd0, 32'd0, 1'b0);
    queue_candle(32'd1, 32'd1, 32'd1, 1'b0);
    queue_candle(32'd0, 32'd0, 32'd0, 1'b1);
    // full-scale seed, full drop on the end candle
    queue_candle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_candle(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 1'b1);
    // trend up, extend, reverse down, extend, reverse up at the end
    queue_candle(32'd1005, 32'd995, 32'd1000, 1'b0);
    queue_candle(32'd1100, 32'd990, 32'd1050, 1'b0);
    queue_candle(32'd1200, 32'd1150, 32'd1180, 1'b0);
    queue_candle(32'd1190, 32'd1100, 32'd1110, 1'b0);
    queue_candle(32'd1080, 32'd1050, 32'd1060, 1'b0);
    queue_candle(32'd1200, 32'd1060, 32'd1190, 1'b1);
    // small wiggle only: the series ends undecided, nothing comes out
    queue_candle(32'd1000, 32'd1000, 32'd1000, 1'b0);
    queue_candle(32'd1010, 32'd990, 32'd1000, 1'b1);
    // one tick short of the threshold, then exactly on it
    queue_candle(32'd65536, 32'd65536, 32'd65536, 1'b0);
    queue_candle(32'd68812, 32'd65536, 32'd68000, 1'b0);
    queue_candle(32'd68813, 32'd65536, 32'd68813, 1'b0);
    queue_candle(32'd68813, 32'd68813, 32'd68813, 1'b1);
    wait_idle();

    // Random phases; the first is busy enough to host the long hold-off.
    phase_dev = '{20'd655, 20'd1, 20'd0, 20'hFFFFF, 20'd3277, 20'd32768};
    phase_len = '{120, 50, 50, 60, 60, 60};
    for (int ph = 0; ph < 6; ph++) begin
      set_deviation(phase_dev[ph]);
      random_candles(phase_len[ph]);
      wait_idle();
    end
    repeat (10) @(posedge clk);

    if (mismatches == 0 && swing_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
